>>> rtl/core/jrrt_pkg.sv
// ---------------------------------------------------------------------------
// jrrt_pkg
// Shared types and operation codes of the job resource reservation table.
// ---------------------------------------------------------------------------
package jrrt_pkg;

  localparam int unsigned CpuW = 12;
  localparam int unsigned MemW = 40;
  localparam int unsigned DiskW = 48;
  localparam int unsigned BwW = 32;
  localparam int unsigned JobW = 16;

  localparam logic [2:0] FUNC_INIT = 3'd0;
  localparam logic [2:0] FUNC_ALLOC = 3'd1;
  localparam logic [2:0] FUNC_DEALLOC = 3'd2;
  localparam logic [2:0] FUNC_EXPAND = 3'd3;
  localparam logic [2:0] FUNC_SHRINK = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_RES = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [2:0] REG_CPUS = 3'd0;
  localparam logic [2:0] REG_MEMORY = 3'd1;
  localparam logic [2:0] REG_DISK = 3'd2;
  localparam logic [2:0] REG_MEMORY_BW = 3'd3;
  localparam logic [2:0] REG_DISK_BW = 3'd4;
  localparam logic [2:0] REG_FABRIC_BW = 3'd5;

  // One set of six resource amounts
  typedef struct packed {
    logic [CpuW-1:0] cpus;
    logic [MemW-1:0] memory;
    logic [DiskW-1:0] disk;
    logic [BwW-1:0] memory_bw;
    logic [BwW-1:0] disk_bw;
    logic [BwW-1:0] fabric_bw;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input item and search the table
    logic execute;  // apply the operation and drive the result
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic busy_hint;
  } dp_status_t;

endpackage

>>> rtl/core/jrrt_ctrl.sv
// ---------------------------------------------------------------------------
// jrrt_ctrl
// Two-step sequencer: capture and search, then read-modify-write.
// ---------------------------------------------------------------------------
module jrrt_ctrl import jrrt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output ctl_t ctl
);

  typedef enum logic [0:0] {S_IDLE, S_EXEC} state_t;
  state_t state;

  assign ctl.capture = start && !busy;
  assign ctl.execute = (state == S_EXEC);

  // state and registered busy
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
            busy <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          busy <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/jrrt_dp.sv
// ---------------------------------------------------------------------------
// jrrt_dp
// Free counters, reservation table, job match and result registers.
// ---------------------------------------------------------------------------
module jrrt_dp import jrrt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  ctl_t             ctl,
  input  res_t             cap,
  input  logic [2:0]       func,
  input  logic [JobW-1:0]  job_id,
  input  res_t             req_in,
  input  logic [CpuW-1:0]  shrink_cpus,
  output logic             done,
  output logic [1:0]       status,
  output logic [CpuW-1:0]  job_cpus,
  output logic [CpuW-1:0]  shrink_left,
  output res_t             free
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TABLE_ENTRIES-1:0] valid;
  logic [JobW-1:0] ent_job [TABLE_ENTRIES];
  res_t ent_res [TABLE_ENTRIES];
  res_t avail;

  // captured item and search results
  logic [2:0] op;
  logic [JobW-1:0] op_job;
  res_t req;
  logic [CpuW-1:0] shr;
  logic hit, has_free;
  logic [IdxW-1:0] hit_idx, free_idx;

  logic m_hit, m_free;
  logic [IdxW-1:0] m_hit_idx, m_free_idx;

  // priority search: lowest matching valid entry, lowest invalid entry
  always_comb begin
    m_hit = 1'b0;
    m_free = 1'b0;
    m_hit_idx = '0;
    m_free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && ent_job[i] == job_id) begin
        m_hit = 1'b1;
        m_hit_idx = IdxW'(i);
      end
      if (!valid[i]) begin
        m_free = 1'b1;
        m_free_idx = IdxW'(i);
      end
    end
  end

  res_t cur, sum, diff, rel;
  logic fits;
  logic [CpuW-1:0] take_c, cpus_after;
  logic [IdxW-1:0] widx;

  assign widx = hit ? hit_idx : free_idx;
  assign cur = hit ? ent_res[hit_idx] : '0;
  assign fits = (req.cpus <= avail.cpus) && (req.memory <= avail.memory) &&
                (req.disk <= avail.disk) && (req.memory_bw <= avail.memory_bw) &&
                (req.disk_bw <= avail.disk_bw) && (req.fabric_bw <= avail.fabric_bw);

  // arithmetic on the six fields
  always_comb begin
    sum.cpus = cur.cpus + req.cpus;
    sum.memory = cur.memory + req.memory;
    sum.disk = cur.disk + req.disk;
    sum.memory_bw = cur.memory_bw + req.memory_bw;
    sum.disk_bw = cur.disk_bw + req.disk_bw;
    sum.fabric_bw = cur.fabric_bw + req.fabric_bw;
    diff.cpus = avail.cpus - req.cpus;
    diff.memory = avail.memory - req.memory;
    diff.disk = avail.disk - req.disk;
    diff.memory_bw = avail.memory_bw - req.memory_bw;
    diff.disk_bw = avail.disk_bw - req.disk_bw;
    diff.fabric_bw = avail.fabric_bw - req.fabric_bw;
    rel.cpus = avail.cpus + cur.cpus;
    rel.memory = avail.memory + cur.memory;
    rel.disk = avail.disk + cur.disk;
    rel.memory_bw = avail.memory_bw + cur.memory_bw;
    rel.disk_bw = avail.disk_bw + cur.disk_bw;
    rel.fabric_bw = avail.fabric_bw + cur.fabric_bw;
    take_c = (cur.cpus > shr) ? shr : cur.cpus;
    cpus_after = cur.cpus - take_c;
  end

  // capture stage
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op <= func;
      op_job <= job_id;
      req <= req_in;
      shr <= shrink_cpus;
      hit <= m_hit;
      hit_idx <= m_hit_idx;
      has_free <= m_free;
      free_idx <= m_free_idx;
    end
  end

  // valid bits, free counters and done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      done <= 1'b0;
      avail <= '0;
    end else begin
      done <= ctl.execute;
      if (ctl.execute) begin
        case (op)
          FUNC_INIT: begin
            valid <= '0;
            avail <= cap;
          end
          FUNC_ALLOC: begin
            if (fits && (hit || has_free)) begin
              valid[widx] <= 1'b1;
              avail <= diff;
            end
          end
          FUNC_DEALLOC: begin
            if (hit) begin
              valid[hit_idx] <= 1'b0;
              avail <= rel;
            end
          end
          FUNC_EXPAND: begin
            if (hit && fits) avail <= diff;
          end
          FUNC_SHRINK: begin
            if (hit) begin
              if (cpus_after == '0) begin
                valid[hit_idx] <= 1'b0;
                avail <= rel;
              end else begin
                avail.cpus <= avail.cpus + take_c;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // table payload and result fields
  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      status <= ST_OK;
      job_cpus <= '0;
      shrink_left <= '0;
      case (op)
        FUNC_ALLOC: begin
          if (!fits) begin
            status <= ST_NO_RES;
            if (hit) job_cpus <= cur.cpus;
          end else if (!hit && !has_free) begin
            status <= ST_FULL;
          end else begin
            ent_job[widx] <= op_job;
            ent_res[widx] <= sum;
            job_cpus <= sum.cpus;
          end
        end
        FUNC_DEALLOC: begin
          if (!hit) status <= ST_NOT_FOUND;
        end
        FUNC_EXPAND: begin
          if (!hit) begin
            status <= ST_NOT_FOUND;
          end else if (!fits) begin
            status <= ST_NO_RES;
            job_cpus <= cur.cpus;
          end else begin
            ent_res[hit_idx] <= sum;
            job_cpus <= sum.cpus;
          end
        end
        FUNC_SHRINK: begin
          if (!hit) begin
            status <= ST_NOT_FOUND;
            shrink_left <= shr;
          end else begin
            shrink_left <= shr - take_c;
            job_cpus <= cpus_after;
            ent_res[hit_idx].cpus <= cpus_after;
          end
        end
        default: ;
      endcase
    end
  end

  assign free = avail;

endmodule

>>> rtl/core/job_resource_reservation_table_top.sv
// ---------------------------------------------------------------------------
// job_resource_reservation_table_top
// Node resource counters with a per-job reservation table.
// ---------------------------------------------------------------------------
// The rising edge that accepts start captures the item together with
// the table search done in that cycle. The next edge applies the
// read-modify-write. done is then high for exactly one cycle with the
// result. busy is high only in the cycle between capture and execute, so a
// new item can be accepted only after the previous one has executed, at the
// edge that ends the done cycle. The receiver cannot stall, and done is a
// one-cycle strobe. The free outputs always show the current counters.
module job_resource_reservation_table_top import jrrt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [DiskW-1:0]  cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        func,
  input  logic [JobW-1:0]   job_id,
  input  logic [CpuW-1:0]   req_cpus,
  input  logic [MemW-1:0]   req_memory,
  input  logic [DiskW-1:0]  req_disk,
  input  logic [BwW-1:0]    req_memory_bw,
  input  logic [BwW-1:0]    req_disk_bw,
  input  logic [BwW-1:0]    req_fabric_bw,
  input  logic [CpuW-1:0]   shrink_cpus,
  output logic              done,
  output logic [1:0]        status,
  output logic [CpuW-1:0]   job_cpus,
  output logic [CpuW-1:0]   shrink_left,
  output logic [CpuW-1:0]   free_cpus,
  output logic [MemW-1:0]   free_memory,
  output logic [DiskW-1:0]  free_disk,
  output logic [BwW-1:0]    free_memory_bw,
  output logic [BwW-1:0]    free_disk_bw,
  output logic [BwW-1:0]    free_fabric_bw
);

  res_t cap, req_bus, free;
  ctl_t ctl;

  // capacity registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CPUS: cap.cpus <= cfg_data[CpuW-1:0];
        REG_MEMORY: cap.memory <= cfg_data[MemW-1:0];
        REG_DISK: cap.disk <= cfg_data;
        REG_MEMORY_BW: cap.memory_bw <= cfg_data[BwW-1:0];
        REG_DISK_BW: cap.disk_bw <= cfg_data[BwW-1:0];
        REG_FABRIC_BW: cap.fabric_bw <= cfg_data[BwW-1:0];
        default: ;
      endcase
    end
  end

  assign req_bus = '{cpus: req_cpus, memory: req_memory, disk: req_disk,
                     memory_bw: req_memory_bw, disk_bw: req_disk_bw,
                     fabric_bw: req_fabric_bw};

  jrrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .ctl(ctl)
  );

  jrrt_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .cap(cap), .func(func), .job_id(job_id),
    .req_in(req_bus), .shrink_cpus(shrink_cpus), .done(done), .status(status),
    .job_cpus(job_cpus), .shrink_left(shrink_left), .free(free)
  );

  assign free_cpus = free.cpus;
  assign free_memory = free.memory;
  assign free_disk = free.disk;
  assign free_memory_bw = free.memory_bw;
  assign free_disk_bw = free.disk_bw;
  assign free_fabric_bw = free.fabric_bw;

  // an accepted item produces exactly one result, after its execute step
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done) else $error("missing result");
  a_no_stray_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without transaction");
  a_no_start_in_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(done)) else $error("back-to-back results");

endmodule
